// ===== hw/rtl/cbl_pkg.sv =====
// Shared types, operation codes and interpolation helpers for the colormap lookup.
// No dependencies; used by colormap_bilinear_lookup_top.
package cbl_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic        operation;
		logic [9:0]  entry_index;
		logic [15:0] write_red;
		logic [15:0] write_green;
		logic [15:0] write_blue;
		logic [15:0] write_alpha;
		logic [15:0] coord_u;
		logic [16:0] coord_v;
	} cmd_t;

	// Same layout as a stored table entry: red in the low 16 bits
	typedef struct packed {
		logic [15:0] alpha;
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} pix_t;

	// (a*(1-t) + b*t) >> 16 rewritten as a + floor((b-a)*t / 2^16); exact since a*2^16
	// carries no fraction. t is Q1.16, at most 1.0.
	function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
			input logic [16:0] t);
		logic signed [16:0] d;
		logic signed [17:0] ts;
		logic signed [34:0] prod;
		logic signed [18:0] sum;
		d    = $signed({1'b0, b}) - $signed({1'b0, a});
		ts   = $signed({1'b0, t});
		prod = d * ts;
		sum  = $signed({3'b000, a}) + 19'(prod >>> 16);
		return sum[15:0];
	endfunction

	function automatic pix_t lerp_pix(input pix_t a, input pix_t b, input logic [16:0] t);
		pix_t r;
		r.red   = lerp16(a.red,   b.red,   t);
		r.green = lerp16(a.green, b.green, t);
		r.blue  = lerp16(a.blue,  b.blue,  t);
		r.alpha = lerp16(a.alpha, b.alpha, t);
		return r;
	endfunction

endpackage

// ===== hw/rtl/cbl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 129
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old word when the same address is written in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/colormap_bilinear_lookup_top.sv =====
// Colormap bilinear lookup: top level, four-bank table and four-stage pipeline.
// Depends on cbl_pkg and cbl_ram.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one item per transfer. A write item
//   (operation = OP_WRITE) stores one RGBA entry; indexes past 2*TABLE_STEPS+1 are
//   dropped. A lookup item (OP_LOOKUP) gives one pixel on the pix channel
//   (pix_valid/pix_ready/pix), in the order the lookups were taken.
//   Throughput: one item per cycle unless stalled, set by the table being split
//   into four banks (entry index mod 4) so the four entries a lookup needs come
//   from four read ports at once. Writes take the same path and touch the table
//   in item order. Stages: u*STEPS and clamp of v; table read; interpolation
//   along u; blend by v into the output register.
//   Stall: when pix_ready is low the output register holds; bubbles further up
//   still fill, and cmd_ready drops only once every stage is occupied.
//   Reset: clears the stage valid bits only. Table contents are undefined until
//   written; lookups must only touch written entries.
module colormap_bilinear_lookup_top #(
	parameter int TABLE_STEPS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cbl_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_ready,
	output cbl_pkg::pix_t pix
);
	import cbl_pkg::*;

	localparam int TABLE_DEPTH = 2 * TABLE_STEPS + 2;
	localparam int BANK_DEPTH  = TABLE_STEPS / 2 + 1;
	localparam int AW          = $clog2(BANK_DEPTH);
	localparam int IW          = $clog2(TABLE_STEPS);
	localparam int PW          = 16 + IW;

	logic en1, en2, en3, en4;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic          op_s1;
	logic [9:0]    idx_s1;
	pix_t          wdat_s1;
	logic [IW-1:0] i_s1;
	logic [15:0]   f_s1, f_s2;
	logic [16:0]   w_s1, w_s2, w_s3;
	logic          odd_s2;
	pix_t          base_s3, alt_s3;
	pix_t          pix_s4;

	logic [PW-1:0] prod_u;
	logic [16:0]   w_clamp;
	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [IW:0]   i_inc;
	logic [AW-1:0] addr_lo, addr_hi;
	logic [63:0]   bank_rd [4];
	pix_t          e0, e1, e2, e3;

	// Elastic chain: a stage loads when empty or when its content moves on
	assign en4       = !vld_s4 || pix_ready;
	assign en3       = !vld_s3 || en4;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign cmd_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= cmd_valid;
			// write items retire once they reach the table
			if (en2) vld_s2 <= vld_s1 && (op_s1 == OP_LOOKUP);
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// Stage 1: split u into step and weight, clamp v
	assign prod_u  = PW'(cmd.coord_u) * PW'(TABLE_STEPS);
	assign w_clamp = (cmd.coord_v > ONE_Q16) ? ONE_Q16 : cmd.coord_v;

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= cmd.operation;
			idx_s1  <= cmd.entry_index;
			wdat_s1 <= '{alpha: cmd.write_alpha, blue: cmd.write_blue,
			             green: cmd.write_green, red: cmd.write_red};
			i_s1    <= prod_u[PW-1:16];
			f_s1    <= prod_u[15:0];
			w_s1    <= w_clamp;
		end
	end

	// Stage 2: table access. Banks 0/1 are read at (i+1)>>1, banks 2/3 at i>>1.
	assign wr_en   = vld_s1 && (op_s1 == OP_WRITE) && en2
	                 && (32'(idx_s1) < 32'(TABLE_DEPTH));
	assign waddr   = AW'(idx_s1 >> 2);
	assign i_inc   = {1'b0, i_s1} + (IW+1)'(1);
	assign addr_lo = AW'(i_s1 >> 1);
	assign addr_hi = AW'(i_inc >> 1);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		cbl_ram #(
			.WIDTH (64),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (wr_en && (idx_s1[1:0] == 2'(b))),
			.waddr (waddr),
			.wdata (wdat_s1),
			.re    (en2),
			.raddr ((b < 2) ? addr_hi : addr_lo),
			.rdata (bank_rd[b])
		);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			f_s2   <= f_s1;
			w_s2   <= w_s1;
			odd_s2 <= i_s1[0];
		end
	end

	// Stage 3: interpolate even and odd pairs along u
	always_comb begin
		if (odd_s2) begin
			e0 = pix_t'(bank_rd[2]);
			e1 = pix_t'(bank_rd[3]);
			e2 = pix_t'(bank_rd[0]);
			e3 = pix_t'(bank_rd[1]);
		end else begin
			e0 = pix_t'(bank_rd[0]);
			e1 = pix_t'(bank_rd[1]);
			e2 = pix_t'(bank_rd[2]);
			e3 = pix_t'(bank_rd[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			base_s3 <= lerp_pix(e0, e2, {1'b0, f_s2});
			alt_s3  <= lerp_pix(e1, e3, {1'b0, f_s2});
			w_s3    <= w_s2;
		end
	end

	// Stage 4: blend toward the alternate color by v
	always_ff @(posedge clk) begin
		if (en4) begin
			pix_s4 <= lerp_pix(base_s3, alt_s3, w_s3);
		end
	end

	assign pix_valid = vld_s4;
	assign pix       = pix_s4;

endmodule

// ===== tb/colormap_bilinear_lookup_top_tb.sv =====
// Self-checking testbench for colormap_bilinear_lookup_top: table writes and bilinear lookups,
// predicted in-house from a shadow copy of the table and compared per channel.
// Depends on cbl_pkg (cmd_t, pix_t, operation codes) and the RTL of the block.
module colormap_bilinear_lookup_top_tb;
	import cbl_pkg::*;

	localparam int STEPS        = 256;
	localparam int DEPTH        = 2 * STEPS + 2;
	localparam int STALL_CYCLES = 80;
	localparam int SETTLE       = 8;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_ready;
	cmd_t  cmd = '0;
	logic  pix_valid;
	logic  pix_ready = 1'b0;
	pix_t  pix;

	// shadow of the color table, what has been loaded, and steps whose four entries exist
	pix_t  color_shadow [DEPTH];
	bit    entry_loaded [DEPTH];
	bit    step_ready [STEPS];
	int    ready_steps [$];
	pix_t  pending_pix [$];

	int    fail_count;
	int    writes_taken;
	int    writes_dropped;
	int    pixels_checked;
	bit    gaps_off;
	logic  steady_ready = 1'b0;
	logic  holding = 1'b0;
	event  long_stall_go;

	colormap_bilinear_lookup_top #(.TABLE_STEPS(STEPS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// (a*(1-t) + b*t) >> 16, truncated
	function automatic logic [15:0] mix_q16(input logic [15:0] a, input logic [15:0] b,
			input logic [16:0] t);
		longint unsigned acc;
		acc = longint'(a) * (longint'(65536) - longint'(t)) + longint'(b) * longint'(t);
		return 16'(acc >> 16);
	endfunction

	function automatic pix_t blend_pixel(input logic [15:0] u, input logic [16:0] v);
		int unsigned p;
		int unsigned step;
		logic [16:0] f;
		logic [16:0] w;
		logic [63:0] e0, e1, e2, e3, r;
		logic [15:0] base_c, alt_c;
		p    = int'(u) * STEPS;
		step = p >> 16;
		f    = 17'(p & 32'h0000_FFFF);
		w    = (v > ONE_Q16) ? ONE_Q16 : v;
		e0   = color_shadow[2 * step];
		e1   = color_shadow[2 * step + 1];
		e2   = color_shadow[2 * step + 2];
		e3   = color_shadow[2 * step + 3];
		for (int c = 0; c < 4; c++) begin
			base_c = mix_q16(e0[16*c +: 16], e2[16*c +: 16], f);
			alt_c  = mix_q16(e1[16*c +: 16], e3[16*c +: 16], f);
			r[16*c +: 16] = mix_q16(base_c, alt_c, w);
		end
		return pix_t'(r);
	endfunction

	// runs at the transfer edge, so writes and lookups update the shadow in item order
	function automatic void accept_cmd(input cmd_t c);
		int idx;
		idx = int'(c.entry_index);
		if (c.operation == OP_LOOKUP) begin
			pending_pix.push_back(blend_pixel(c.coord_u, c.coord_v));
		end else if (idx < DEPTH) begin
			color_shadow[idx] = {c.write_alpha, c.write_blue, c.write_green, c.write_red};
			entry_loaded[idx] = 1'b1;
			writes_taken++;
			for (int s = idx / 2 - 1; s <= idx / 2; s++) begin
				if (s >= 0 && s < STEPS && !step_ready[s] && entry_loaded[2*s]
						&& entry_loaded[2*s+1] && entry_loaded[2*s+2] && entry_loaded[2*s+3]) begin
					step_ready[s] = 1'b1;
					ready_steps.push_back(s);
				end
			end
		end else begin
			writes_dropped++;
		end
	endfunction

	function automatic logic [15:0] random_level();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pix_t random_color();
		pix_t c;
		c.red   = random_level();
		c.green = random_level();
		c.blue  = random_level();
		c.alpha = random_level();
		return c;
	endfunction

	function automatic logic [16:0] random_weight();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return ONE_Q16;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(65535));
		endcase
	endfunction

	// u's top byte is the step (STEPS = 256); prefer a given step half the time
	function automatic logic [15:0] pick_coord(input int prefer);
		int step;
		int low_u;
		if (prefer >= 0 && $urandom_range(1))
			step = prefer;
		else
			step = ready_steps[$urandom_range(ready_steps.size() - 1)];
		if ($urandom_range(9) == 0)
			low_u = $urandom_range(1) ? 255 : 0;
		else
			low_u = $urandom_range(255);
		return {8'(step), 8'(low_u)};
	endfunction

	function automatic cmd_t write_cmd(input int idx, input pix_t c);
		cmd_t x;
		x.operation   = OP_WRITE;
		x.entry_index = 10'(idx);
		x.write_red   = c.red;
		x.write_green = c.green;
		x.write_blue  = c.blue;
		x.write_alpha = c.alpha;
		x.coord_u     = 16'($urandom);
		x.coord_v     = 17'($urandom);
		return x;
	endfunction

	function automatic cmd_t lookup_cmd(input logic [15:0] u, input logic [16:0] v);
		cmd_t x;
		x.operation   = OP_LOOKUP;
		x.entry_index = 10'($urandom);
		x.write_red   = 16'($urandom);
		x.write_green = 16'($urandom);
		x.write_blue  = 16'($urandom);
		x.write_alpha = 16'($urandom);
		x.coord_u     = u;
		x.coord_v     = v;
		return x;
	endfunction

	task automatic send_cmd(input cmd_t c);
		while (!gaps_off && $urandom_range(99) < 24) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		accept_cmd(c);
	endtask

	task automatic wait_for_pixels();
		cmd_valid <= 1'b0;
		while (pending_pix.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly: load a whole step, then look it up (and other loaded steps) right behind
	task automatic run_mix(input int n_items);
		int done_items;
		int roll;
		int k;
		int s0;
		int m;
		done_items = 0;
		while (done_items < n_items) begin
			roll = $urandom_range(99);
			if (roll < 65) begin
				k  = $urandom_range(STEPS - 1);
				s0 = $urandom_range(3);
				for (int j = 0; j < 4; j++)
					send_cmd(write_cmd(2 * k + (s0 + j) % 4, random_color()));
				m = $urandom_range(1, 8);
				for (int j = 0; j < m; j++)
					send_cmd(lookup_cmd(pick_coord(k), random_weight()));
				done_items += 4 + m;
			end else if (roll < 75) begin
				send_cmd(write_cmd($urandom_range(DEPTH, 1023), random_color()));
			end else if (roll < 85) begin
				send_cmd(write_cmd($urandom_range(DEPTH - 1), random_color()));
				done_items++;
			end else begin
				m = $urandom_range(1, 4);
				for (int j = 0; j < m; j++)
					send_cmd(lookup_cmd(pick_coord(-1), random_weight()));
				done_items += m;
			end
		end
	endtask

	task automatic test_edges();
		pix_t ones;
		pix_t zeros;
		pix_t mixed;
		ones  = '1;
		zeros = '0;
		mixed = {16'h8000, 16'h0001, 16'hFFFE, 16'h1234};
		// first and last step, extreme colors
		send_cmd(write_cmd(0, zeros));
		send_cmd(write_cmd(1, ones));
		send_cmd(write_cmd(2, ones));
		send_cmd(write_cmd(3, mixed));
		send_cmd(write_cmd(DEPTH - 4, ones));
		send_cmd(write_cmd(DEPTH - 3, mixed));
		send_cmd(write_cmd(DEPTH - 2, zeros));
		send_cmd(write_cmd(DEPTH - 1, ones));
		// writes past the table end are dropped
		send_cmd(write_cmd(DEPTH, ones));
		send_cmd(write_cmd(1023, ones));
		send_cmd(lookup_cmd(16'h0000, 17'd0));
		send_cmd(lookup_cmd(16'h0000, ONE_Q16));
		send_cmd(lookup_cmd(16'h00FF, 17'h08000));
		send_cmd(lookup_cmd(16'h0080, 17'd1));
		send_cmd(lookup_cmd(16'hFF00, 17'h0FFFF));
		send_cmd(lookup_cmd(16'hFFFF, ONE_Q16));
		// v above one clamps
		send_cmd(lookup_cmd(16'hFFFF, 17'h1FFFF));
		send_cmd(lookup_cmd(16'h00FF, 17'h10001));
		wait_for_pixels();
	endtask

	task automatic test_back_to_back();
		gaps_off = 1'b1;
		steady_ready <= 1'b1;
		run_mix(120);
		gaps_off = 1'b0;
		steady_ready <= 1'b0;
		wait_for_pixels();
	endtask

	// receiver holds off long enough that the pipeline fills and cmd_ready drops
	task automatic test_full_stall();
		-> long_stall_go;
		gaps_off = 1'b1;
		for (int j = 0; j < 24; j++)
			send_cmd(lookup_cmd(pick_coord(-1), random_weight()));
		gaps_off = 1'b0;
		wait_for_pixels();
	endtask

	task automatic test_random_mix();
		run_mix(480);
		wait_for_pixels();
	endtask

	always begin
		@(long_stall_go);
		holding <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || holding)
			pix_ready <= 1'b0;
		else if (steady_ready)
			pix_ready <= 1'b1;
		else
			pix_ready <= ($urandom_range(99) >= 24);
	end

	task automatic check_channel(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (pending_pix.size() == 0) begin
				$error("pixel transfer with no lookup pending: %h", pix);
				fail_count++;
			end else begin
				want = pending_pix.pop_front();
				check_channel("red",   want.red,   pix.red);
				check_channel("green", want.green, pix.green);
				check_channel("blue",  want.blue,  pix.blue);
				check_channel("alpha", want.alpha, pix.alpha);
				pixels_checked++;
			end
		end
	end

	initial begin
		#200000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_back_to_back();
		test_full_stall();
		test_random_mix();
		if (pending_pix.size() != 0) begin
			$error("%0d lookups never produced a pixel", pending_pix.size());
			fail_count++;
		end
		$display("Checked %0d pixels; %0d entries written, %0d out-of-range writes dropped.",
			pixels_checked, writes_taken, writes_dropped);
		$display("%0d of %0d steps loaded, incl. a full-pipeline stall.",
			ready_steps.size(), STEPS);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== colormap_bilinear_lookup_top.f =====
hw/rtl/cbl_pkg.sv
hw/rtl/cbl_ram.sv
hw/rtl/colormap_bilinear_lookup_top.sv
tb/colormap_bilinear_lookup_top_tb.sv
